FILE: design/mnp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mnp_pkg
// Shared types, character codes and tables of the melody note parser.
// ----------------------------------------------------------------------------
package mnp_pkg;

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_A     = 8'h41;
  localparam logic [7:0] CH_G     = 8'h47;
  localparam logic [7:0] CH_P     = 8'h50;

  localparam logic [3:0]  OCTAVE_RESET   = 4'd4;
  localparam logic [7:0]  FRACTION_RESET = 8'd4;
  localparam logic [15:0] WHOLE_RESET    = 16'd500;
  localparam logic [21:0] FREQ_MAX       = 22'h3FFFFF;

  // One finished token, passed from the parser to the arithmetic stage.
  typedef struct packed {
    logic       err;
    logic       pause;
    logic [2:0] letter;
    logic [3:0] octave;
    logic       sharp;
    logic [7:0] fraction;
  } tok_t;

  // Semitone above C for the letters A to G.
  function automatic logic [3:0] letter_semi(input logic [2:0] letter);
    logic [3:0] s;
    case (letter)
      3'd0: s = 4'd9;
      3'd1: s = 4'd11;
      3'd2: s = 4'd0;
      3'd3: s = 4'd2;
      3'd4: s = 4'd4;
      3'd5: s = 4'd5;
      3'd6: s = 4'd7;
      default: s = 4'd0;
    endcase
    return s;
  endfunction

  // Octave-4 frequency of each semitone in Q16, A4 at 440 Hz.
  function automatic logic [24:0] semitone_q16(input logic [3:0] k);
    logic [24:0] f;
    case (k)
      4'd0:  f = 25'd17145893;
      4'd1:  f = 25'd18165441;
      4'd2:  f = 25'd19245614;
      4'd3:  f = 25'd20390018;
      4'd4:  f = 25'd21602472;
      4'd5:  f = 25'd22887021;
      4'd6:  f = 25'd24247954;
      4'd7:  f = 25'd25689813;
      4'd8:  f = 25'd27217409;
      4'd9:  f = 25'd28835840;
      4'd10: f = 25'd30550508;
      4'd11: f = 25'd32367136;
      default: f = 25'd0;
    endcase
    return f;
  endfunction

endpackage

FILE: design/mnp_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mnp_front
// Parser: one character per accepted cycle; a record per token up to an error.
// ----------------------------------------------------------------------------
module mnp_front (
  input  logic          clk,
  input  logic          rst,
  input  logic [7:0]    char_code,
  input  logic          end_of_melody,
  input  logic          char_accept,
  output logic          tok_push,
  output mnp_pkg::tok_t tok_data
);
  import mnp_pkg::*;

  typedef enum logic [2:0] {
    P_START, P_OCT_NONE, P_OCT_DIG, P_CHECK, P_FRAC, P_SKIP, P_BAD
  } phase_t;

  phase_t     phase, phase_a;
  logic [2:0] letter, letter_a;
  logic       pause, pause_a;
  logic [3:0] octave, octave_a;
  logic       sharp, sharp_a;
  logic [7:0] fraction, fraction_a;
  logic       halted;

  logic       is_space, is_digit, tok_end;
  logic [3:0] digit;
  logic [6:0] oct_val;

  assign is_space = (char_code == CH_SPACE);
  assign is_digit = (char_code >= CH_ZERO) && (char_code <= CH_NINE);
  assign digit    = char_code[3:0];
  assign tok_end  = is_space || end_of_melody;

  always_comb begin
    phase_a    = phase;
    letter_a   = letter;
    pause_a    = pause;
    octave_a   = octave;
    sharp_a    = sharp;
    fraction_a = fraction;
    oct_val    = 7'd0;
    if (!is_space) begin
      case (phase)
        P_START: begin
          if (char_code == CH_P) begin
            pause_a = 1'b1;
            phase_a = P_CHECK;
          end else if (char_code >= CH_A && char_code <= CH_G) begin
            letter_a = char_code[2:0] - CH_A[2:0];
            phase_a  = P_OCT_NONE;
          end else begin
            phase_a = P_BAD;
          end
        end
        P_OCT_NONE, P_OCT_DIG: begin
          if (is_digit) begin
            if (phase == P_OCT_NONE) begin
              oct_val = {3'd0, digit};
            end else begin
              oct_val = {3'd0, octave} * 7'd10 + {3'd0, digit};
            end
            if (oct_val > 7'd9) begin
              phase_a = P_BAD;
            end else begin
              octave_a = oct_val[3:0];
              phase_a  = P_OCT_DIG;
            end
          end else if (char_code == CH_HASH) begin
            sharp_a = 1'b1;
            phase_a = P_CHECK;
          end else if (char_code == CH_SLASH) begin
            fraction_a = 8'd0;
            phase_a    = P_FRAC;
          end else begin
            phase_a = P_SKIP;
          end
        end
        P_CHECK: begin
          if (char_code == CH_SLASH) begin
            fraction_a = 8'd0;
            phase_a    = P_FRAC;
          end else begin
            phase_a = P_SKIP;
          end
        end
        P_FRAC: begin
          if (is_digit) begin
            fraction_a = 8'((fraction << 3) + (fraction << 1) + {4'd0, digit});
          end else begin
            phase_a = P_SKIP;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    tok_push          = char_accept && !halted && tok_end;
    tok_data.err      = (phase_a == P_START) || (phase_a == P_BAD) ||
                        (fraction_a == 8'd0);
    tok_data.pause    = pause_a;
    tok_data.letter   = letter_a;
    tok_data.octave   = octave_a;
    tok_data.sharp    = sharp_a;
    tok_data.fraction = fraction_a;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase    <= P_START;
      letter   <= 3'd0;
      pause    <= 1'b0;
      octave   <= OCTAVE_RESET;
      sharp    <= 1'b0;
      fraction <= FRACTION_RESET;
      halted   <= 1'b0;
    end else if (char_accept) begin
      if (end_of_melody || (!halted && is_space)) begin
        phase    <= P_START;
        letter   <= 3'd0;
        pause    <= 1'b0;
        octave   <= OCTAVE_RESET;
        sharp    <= 1'b0;
        fraction <= FRACTION_RESET;
      end else if (!halted) begin
        phase    <= phase_a;
        letter   <= letter_a;
        pause    <= pause_a;
        octave   <= octave_a;
        sharp    <= sharp_a;
        fraction <= fraction_a;
      end
      if (end_of_melody) begin
        halted <= 1'b0;
      end else if (tok_push && tok_data.err) begin
        halted <= 1'b1;
      end
    end
  end

endmodule

FILE: design/mnp_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mnp_queue
// Small token queue between the parser and the arithmetic stage.
// ----------------------------------------------------------------------------
module mnp_queue #(
  parameter int DEPTH = 4
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          wr_en,
  input  mnp_pkg::tok_t wr_data,
  output logic          q_full,
  input  logic          rd_en,
  output logic          q_valid,
  output mnp_pkg::tok_t rd_data
);
  import mnp_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

  tok_t          mem [DEPTH];
  logic [AW-1:0] wr_ptr, rd_ptr;
  logic [CW-1:0] count;

  assign q_full  = (count == CW'(DEPTH));
  assign q_valid = (count != '0);
  assign rd_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= (wr_ptr == LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (rd_en) begin
        rd_ptr <= (rd_ptr == LAST) ? '0 : rd_ptr + 1'b1;
      end
      if (wr_en && !rd_en) begin
        count <= count + 1'b1;
      end else if (rd_en && !wr_en) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

FILE: design/mnp_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mnp_back
// Note arithmetic: frequency from the semitone table, duration by a
// bit-serial divider, and the result register.
// ----------------------------------------------------------------------------
module mnp_back #(
  parameter int FREQ_FRAC_BITS = 8
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          cfg_we,
  input  logic [15:0]   cfg_data,
  input  logic          q_valid,
  input  mnp_pkg::tok_t q_data,
  output logic          q_pop,
  output logic          res_valid,
  input  logic          res_pop,
  output logic          is_pause,
  output logic [21:0]   frequency_q8,
  output logic [15:0]   note_duration,
  output logic          parse_error
);
  import mnp_pkg::*;

  localparam int SH = 20 - FREQ_FRAC_BITS;
  localparam logic [35:0] ROUND = 36'(1) << (SH - 1);

  typedef enum logic [1:0] {B_IDLE, B_DIV, B_DONE} bstate_t;

  bstate_t     state;
  logic [15:0] whole;
  logic        err, pause;
  logic [3:0]  semi_k, oct_o;
  logic [7:0]  divisor, rem;
  logic [15:0] quo;
  logic [3:0]  cnt;
  logic [21:0] freq;

  logic [4:0]  semi_sum;
  logic [8:0]  rem_sh;
  logic        fits;
  logic [7:0]  rem_next;
  logic [15:0] quo_next;
  logic [35:0] raw, rounded;
  logic [21:0] freq_next;
  logic        load;

  assign q_pop    = (state == B_IDLE) && q_valid;
  assign semi_sum = {1'b0, letter_semi(q_data.letter)} + {4'd0, q_data.sharp};
  assign load     = (state == B_DONE) && (!res_valid || res_pop);

  // Restoring division, one quotient bit per cycle.
  always_comb begin
    rem_sh   = {rem, quo[15]};
    fits     = (rem_sh >= {1'b0, divisor});
    rem_next = fits ? 8'(rem_sh - {1'b0, divisor}) : rem_sh[7:0];
    quo_next = {quo[14:0], fits};
  end

  always_comb begin
    raw       = {11'd0, semitone_q16(semi_k)} << oct_o;
    rounded   = (raw + ROUND) >> SH;
    freq_next = (rounded > {14'd0, FREQ_MAX}) ? FREQ_MAX : rounded[21:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= B_IDLE;
      whole       <= WHOLE_RESET;
      res_valid   <= 1'b0;
      cnt         <= 4'd0;
    end else begin
      if (cfg_we) begin
        whole <= cfg_data;
      end
      case (state)
        B_IDLE: begin
          if (q_valid) begin
            err     <= q_data.err;
            pause   <= q_data.pause;
            divisor <= q_data.fraction;
            quo     <= whole;
            rem     <= 8'd0;
            cnt     <= 4'd0;
            if (semi_sum == 5'd12) begin
              semi_k <= 4'd0;
              oct_o  <= q_data.octave + 4'd1;
            end else begin
              semi_k <= semi_sum[3:0];
              oct_o  <= q_data.octave;
            end
            state <= q_data.err ? B_DONE : B_DIV;
          end
        end
        B_DIV: begin
          rem  <= rem_next;
          quo  <= quo_next;
          freq <= freq_next;
          cnt  <= cnt + 4'd1;
          if (cnt == 4'd15) begin
            state <= B_DONE;
          end
        end
        B_DONE: begin
          if (load) begin
            state <= B_IDLE;
          end
        end
        default: begin
          state <= B_IDLE;
        end
      endcase
      if (load) begin
        res_valid     <= 1'b1;
        parse_error   <= err;
        is_pause      <= !err && pause;
        frequency_q8  <= (err || pause) ? 22'd0 : freq;
        note_duration <= err ? 16'd0 : quo;
      end else if (res_pop) begin
        res_valid <= 1'b0;
      end
    end
  end

endmodule

FILE: design/melody_note_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// melody_note_parser
// Parses a melody string one character per transfer and delivers one note
// result (frequency, duration or error) per token, up to the first error.
// ----------------------------------------------------------------------------
//
//  Channel   Handshake            Payload
//  -------   ------------------   ------------------------------------------
//  input     push / full          char_code, end_of_melody
//  result    pop / empty          is_pause, frequency_q8, note_duration,
//                                 parse_error
//  config    cfg_valid/cfg_ready  cfg_data (whole-note duration in ms)
//
// The parser takes one character per cycle; a character transfer is refused
// only while the token queue is full. Each note or pause token then passes
// through the arithmetic stage: a fetch, the bit-serial duration divider and
// a load of the result register, which waits while a result is unread; an
// error token skips the divider. Reset is synchronous and needs no clearing
// pass; the whole-note duration returns to 500 ms. The result register holds
// a waiting result while the parser keeps taking characters into the queue.
//
module melody_note_parser #(
  parameter int FREQ_FRAC_BITS    = 8,
  parameter int TOKEN_QUEUE_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic [7:0]  char_code,
  input  logic        end_of_melody,
  input  logic        push,
  output logic        full,
  output logic        is_pause,
  output logic [21:0] frequency_q8,
  output logic [15:0] note_duration,
  output logic        parse_error,
  output logic        empty,
  input  logic        pop,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data
);
  import mnp_pkg::*;

  logic char_accept;
  logic tok_push, q_full, q_valid, q_pop, res_valid;
  tok_t tok_data, q_data;

  // A character transfers whenever the queue can take a token, since any
  // character may close one.
  assign full        = q_full;
  assign char_accept = push && !q_full;
  assign empty       = !res_valid;
  assign cfg_ready   = 1'b1;

  mnp_front u_front (
    .clk           (clk),
    .rst           (rst),
    .char_code     (char_code),
    .end_of_melody (end_of_melody),
    .char_accept   (char_accept),
    .tok_push      (tok_push),
    .tok_data      (tok_data)
  );

  mnp_queue #(
    .DEPTH (TOKEN_QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (tok_push),
    .wr_data (tok_data),
    .q_full  (q_full),
    .rd_en   (q_pop),
    .q_valid (q_valid),
    .rd_data (q_data)
  );

  // The arithmetic stage pops a token, works it out and parks the result in
  // its output register until the consumer pops it.
  mnp_back #(
    .FREQ_FRAC_BITS (FREQ_FRAC_BITS)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_valid),
    .cfg_data      (cfg_data),
    .q_valid       (q_valid),
    .q_data        (q_data),
    .q_pop         (q_pop),
    .res_valid     (res_valid),
    .res_pop       (pop),
    .is_pause      (is_pause),
    .frequency_q8  (frequency_q8),
    .note_duration (note_duration),
    .parse_error   (parse_error)
  );

endmodule
